// ----- sv/bfs_pkg.sv -----
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared constants, command codes and control structs for the single-step
// Brainfuck machine.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_EXEC    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CH_RIGHT = 8'h3E;  // >
  localparam logic [7:0] CH_LEFT  = 8'h3C;  // <
  localparam logic [7:0] CH_INC   = 8'h2B;  // +
  localparam logic [7:0] CH_DEC   = 8'h2D;  // -
  localparam logic [7:0] CH_OUT   = 8'h2E;  // .
  localparam logic [7:0] CH_IN    = 8'h2C;  // ,
  localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]

  typedef struct packed {
    logic load;
    logic fetch;
    logic exec;
    logic scan_start;
    logic scan_rd;
    logic scan_step;
    logic scan_end;
    logic scan_hit;
    logic finish;
    logic report;
    logic restart;
    logic clr;
  } bfs_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_oob;
    logic scan_match;
    logic scan_edge;
    logic clr_last;
    logic out_free;
  } bfs_sts_t;

endpackage

// ----- sv/brainfuck_single_step_machine.sv -----
// ----------------------------------------------------------------------------
// brainfuck_single_step_machine
// Single-step Brainfuck machine: program load, one-instruction execute and
// run restart, one result transfer per input transfer.
//
//   Channel | Direction | tdata (low bit up)                          | tuser
//   in_     | slave     | load_address, load_byte, input_byte,        | mode
//           |           | input_end                                   |
//   out_    | master    | program_counter, out_value, input_taken,    | out_valid
//           |           | status, zero fill                           |
//   cfg_    | slave     | program_length (cfg_data)                   | -
//
// Load, restart report and plain instructions accept the item, reading program
// store and tape for an instruction, then commit and load the result register.
// A bracket steps through accept, scan setup, a read and a compare per program
// byte walked (one program store read port) and commit; a forward scan that
// runs past the program end adds a bound check before the commit.
// Reset and every restart run a tape clearing pass over all TAPE_DEPTH cells
// with in_tready low; cfg writes are taken at any time.
// A stalled result holds in the output register; the next item is taken but
// its commit waits for it.
// ----------------------------------------------------------------------------
module brainfuck_single_step_machine #(
  parameter int PROGRAM_DEPTH = 128,
  parameter int TAPE_DEPTH    = 128,
  parameter int CELL_WIDTH    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // load_address[6:0], load_byte[14:7],
                                  // input_byte[22:15], input_end[23]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // program_counter[7:0], out_value[23:8],
                                  // input_taken[24], status[26:25], zero[31:27]
  output logic [0:0]  out_tuser,  // out_valid[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // program_length
);

  bfs_pkg::bfs_cmd_t cmd;
  bfs_pkg::bfs_sts_t sts;

  assign cfg_ready = 1'b1;

  bfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfs_datapath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .TAPE_DEPTH    (TAPE_DEPTH),
    .CELL_WIDTH    (CELL_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.fetch, cmd.exec, cmd.finish, cmd.report, cmd.restart, cmd.clr,
              cmd.load}))
    else $error("conflicting datapath commands");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_tready)
    else $error("input ready during tape clear");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[26:25] != 2'b11)
    else $error("invalid status code");

endmodule

// ----- sv/bfs_datapath.sv -----
// ----------------------------------------------------------------------------
// bfs_datapath
// Program store, tape, pointers, bracket scan registers and the result
// register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module bfs_datapath #(
  parameter int PROGRAM_DEPTH = 128,
  parameter int TAPE_DEPTH    = 128,
  parameter int CELL_WIDTH    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bfs_pkg::bfs_cmd_t                   cmd,
  output bfs_pkg::bfs_sts_t                   sts,
  input  logic [bfs_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                cfg_valid,
  input  logic [7:0]                          cfg_data,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [bfs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [0:0]                          out_tuser
);

  localparam int PAW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int PCB = $clog2(PROGRAM_DEPTH + 1);
  localparam int LW  = (PCB > 8) ? PCB : 8;
  localparam int TAW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam logic [LW-1:0]  PDEPTH  = LW'(PROGRAM_DEPTH);
  localparam logic [TAW-1:0] DP_LAST = TAW'(TAPE_DEPTH - 1);

  logic [7:0]            prog_mem [PROGRAM_DEPTH];
  logic [CELL_WIDTH-1:0] tape_mem [TAPE_DEPTH];

  logic [PAW-1:0] wrap_tab [128];

  logic [7:0]            len_r;
  logic [LW-1:0]         pc_r, pc_nxt;
  logic [TAW-1:0]        dp_r, dp_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [TAW-1:0]        clr_r, clr_nxt;
  logic                  out_tvalid_r;
  logic [bfs_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [0:0]            out_tuser_r;

  logic [LW-1:0]         scan_r, depth_r, jump_r;
  logic                  fwd_r, found_r;
  logic [7:0]            ib_r;
  logic                  ie_r;
  logic [7:0]            ch_r;
  logic [CELL_WIDTH-1:0] cell_r;

  logic [LW-1:0]         lim, len_ext;
  logic                  in_range;
  logic [PAW-1:0]        prog_raddr;
  logic                  tape_we;
  logic [TAW-1:0]        tape_waddr;
  logic [CELL_WIDTH-1:0] tape_wdata;
  logic                  emit, take, out_load, step, jump_take;
  logic [7:0]            open_ch, close_ch;

  logic [6:0] ld_addr;
  logic [7:0] ld_byte;

  assign ld_addr = in_tdata[6:0];
  assign ld_byte = in_tdata[14:7];

  for (genvar g = 0; g < 128; g++) begin : g_wrap
    assign wrap_tab[g] = PAW'(g % PROGRAM_DEPTH);
  end

  assign len_ext  = LW'(len_r);
  assign lim      = (len_ext > PDEPTH) ? PDEPTH : len_ext;
  assign in_range = (pc_r < lim);
  assign open_ch  = fwd_r ? bfs_pkg::CH_OPEN : bfs_pkg::CH_CLOSE;
  assign close_ch = fwd_r ? bfs_pkg::CH_CLOSE : bfs_pkg::CH_OPEN;
  assign jump_take = fwd_r ? (cell_r == '0) : (cell_r != '0);

  assign sts.need_scan  = (st_r == bfs_pkg::ST_RUN) && in_range &&
                          ((ch_r == bfs_pkg::CH_OPEN) ||
                           ((ch_r == bfs_pkg::CH_CLOSE) && (pc_r != '0)));
  assign sts.scan_oob   = fwd_r && (scan_r >= lim);
  assign sts.scan_match = (depth_r == '0) && (ch_r == close_ch);
  assign sts.scan_edge  = !fwd_r && (scan_r == '0);
  assign sts.clr_last   = (clr_r == DP_LAST);
  assign sts.out_free   = !out_tvalid_r || out_tready;

  assign prog_raddr = cmd.scan_rd ? scan_r[PAW-1:0] : pc_r[PAW-1:0];

  always_comb begin
    pc_nxt     = pc_r;
    st_nxt     = st_r;
    dp_nxt     = dp_r;
    clr_nxt    = clr_r;
    tape_we    = 1'b0;
    tape_waddr = dp_r;
    tape_wdata = cell_r;
    emit       = 1'b0;
    take       = 1'b0;
    out_load   = 1'b0;
    step       = 1'b0;
    if (cmd.report) begin
      out_load = 1'b1;
    end
    if (cmd.restart) begin
      pc_nxt   = '0;
      st_nxt   = bfs_pkg::ST_RUN;
      dp_nxt   = '0;
      clr_nxt  = '0;
      out_load = 1'b1;
    end
    if (cmd.exec) begin
      out_load = 1'b1;
      if (st_r == bfs_pkg::ST_RUN) begin
        if (!in_range) begin
          st_nxt = bfs_pkg::ST_HALT;
        end else begin
          step = 1'b1;
          case (ch_r)
            bfs_pkg::CH_RIGHT: dp_nxt = (dp_r == DP_LAST) ? '0 : dp_r + TAW'(1);
            bfs_pkg::CH_LEFT:  dp_nxt = (dp_r == '0) ? DP_LAST : dp_r - TAW'(1);
            bfs_pkg::CH_INC: begin
              tape_we    = 1'b1;
              tape_wdata = cell_r + CELL_WIDTH'(1);
            end
            bfs_pkg::CH_DEC: begin
              tape_we    = 1'b1;
              tape_wdata = cell_r - CELL_WIDTH'(1);
            end
            bfs_pkg::CH_OUT: emit = 1'b1;
            bfs_pkg::CH_IN: begin
              tape_we    = 1'b1;
              tape_wdata = ie_r ? '1 : CELL_WIDTH'(ib_r);
              take       = 1'b1;
            end
            bfs_pkg::CH_CLOSE: begin
              st_nxt = bfs_pkg::ST_ERR;
              step   = 1'b0;
            end
            default: ;
          endcase
          if (step) begin
            pc_nxt = pc_r + LW'(1);
            if (pc_nxt >= lim) begin
              st_nxt = bfs_pkg::ST_HALT;
            end
          end
        end
      end
    end
    if (cmd.finish) begin
      out_load = 1'b1;
      if (found_r) begin
        pc_nxt = jump_r;
        st_nxt = (jump_r >= lim) ? bfs_pkg::ST_HALT : bfs_pkg::ST_RUN;
      end else begin
        st_nxt = bfs_pkg::ST_ERR;
      end
    end
    if (cmd.clr) begin
      tape_we    = 1'b1;
      tape_waddr = clr_r;
      tape_wdata = '0;
      clr_nxt    = sts.clr_last ? '0 : clr_r + TAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prog_mem[wrap_tab[ld_addr]] <= ld_byte;
    end
    if (cmd.fetch || cmd.scan_rd) begin
      ch_r <= prog_mem[prog_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    if (cmd.fetch) begin
      cell_r <= tape_mem[dp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      pc_r         <= '0;
      dp_r         <= '0;
      st_r         <= bfs_pkg::ST_RUN;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_data;
      end
      pc_r  <= pc_nxt;
      dp_r  <= dp_nxt;
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      ib_r <= in_tdata[22:15];
      ie_r <= in_tdata[23];
    end
    if (cmd.scan_start) begin
      fwd_r   <= (ch_r == bfs_pkg::CH_OPEN);
      scan_r  <= (ch_r == bfs_pkg::CH_OPEN) ? pc_r + LW'(1) : pc_r - LW'(1);
      depth_r <= '0;
    end
    if (cmd.scan_step) begin
      if (ch_r == open_ch) begin
        depth_r <= depth_r + LW'(1);
      end else if (ch_r == close_ch) begin
        depth_r <= depth_r - LW'(1);
      end
      scan_r <= fwd_r ? scan_r + LW'(1) : scan_r - LW'(1);
    end
    if (cmd.scan_end) begin
      found_r <= cmd.scan_hit;
      jump_r  <= jump_take ? scan_r + LW'(1) : pc_r + LW'(1);
    end
    if (out_load) begin
      out_tdata_r <= {5'b0, st_nxt, take, (emit ? 16'(cell_r) : 16'd0), pc_nxt[7:0]};
      out_tuser_r <= emit;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- sv/bfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfs_ctrl
// Sequencer: accepts one item at a time, steps the datapath through fetch,
// execute, bracket scan, tape clearing and result hand-off.
// ----------------------------------------------------------------------------
module bfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [1:0]        in_tuser,
  output logic              in_tready,
  input  bfs_pkg::bfs_sts_t sts,
  output bfs_pkg::bfs_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REPORT,
    S_RESTART,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            bfs_pkg::MODE_LOAD: begin
              cmd.load  = 1'b1;
              state_nxt = S_REPORT;
            end
            bfs_pkg::MODE_EXEC: begin
              cmd.fetch = 1'b1;
              state_nxt = S_EXEC;
            end
            bfs_pkg::MODE_RESTART: state_nxt = S_RESTART;
            default:               state_nxt = S_REPORT;
          endcase
        end
      end
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.report = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RESTART: begin
        if (sts.out_free) begin
          cmd.restart = 1'b1;
          state_nxt   = S_CLEAR;
        end
      end
      S_EXEC: begin
        if (sts.need_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN_RD;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_oob) begin
          cmd.scan_end = 1'b1;
          state_nxt    = S_FINISH;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.scan_match) begin
          cmd.scan_end = 1'b1;
          cmd.scan_hit = 1'b1;
          state_nxt    = S_FINISH;
        end else if (sts.scan_edge) begin
          cmd.scan_end = 1'b1;
          state_nxt    = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
